/* rtl/core/mlpr_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mlpr_pkg
// Shared types and fixed constants for the page-mode LCD refresh block.
// ---------------------------------------------------------------------------
package mlpr_pkg;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_CLEAR  = 2'd0,
        ST_IDLE   = 2'd1,
        ST_GATHER = 2'd2,
        ST_EMIT   = 2'd3
    } mlpr_state_t;

    // Input kinds carried in tuser
    localparam logic FUNC_WRITE   = 1'b0;
    localparam logic FUNC_REFRESH = 1'b1;

    // Panel command bases
    localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
    localparam logic [7:0] CMD_COL_LOW   = 8'h00;
    localparam logic [7:0] CMD_COL_HIGH  = 8'h10;

    // Command steps at the head of every page
    localparam int unsigned CMD_STEPS = 3;

    // Rows per page, and bits gathered per data byte
    localparam int unsigned PAGE_ROWS = 8;

    // Last cycle index of a gather pass (8 reads through the registered read port)
    localparam logic [3:0] GATHER_LAST = 4'd8;

endpackage

/* rtl/core/mlpr_ram.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mlpr_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module mlpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

/* rtl/core/mono_lcd_page_refresh.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mono_lcd_page_refresh
// Framebuffer and refresh byte sequencer for a page-mode monochrome LCD.
// ---------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): tuser selects the kind of word. tuser = 0 writes
//   fb_byte into framebuffer byte fb_address (ignored past the end of the
//   store, no output). tuser = 1 requests the next byte of the endless
//   refresh sequence: per page, the page command, the two column address
//   commands, then PANEL_WIDTH data bytes, each one column of 8 pixels.
//   Output stream (m_*): tuser = 1 marks a data byte, tlast marks the final
//   data byte of a frame.
//   Config channel (cfg_*): column offset, always ready.
// Timing:
//   One word in work at a time. A command byte goes from the request
//   through EMIT to the output register; a data byte first passes GATHER,
//   built from 8 sequential framebuffer reads through the single RAM read
//   port and its registered read data. Throughput: 1 write per cycle while
//   idle; the next refresh request waits until the last one leaves EMIT.
// Reset:
//   After rst_n releases, a clearing pass zeroes all PANEL_WIDTH*PANEL_HEIGHT/8
//   framebuffer bytes (1024 at the defaults), one byte per cycle;
//   s_tready stays low during it. Refresh restarts at page 0, step 0.
// Stall:
//   A finished byte waits in the output register; one more result can be
//   prepared behind it, after which s_tready stays low until m_tready.
// ---------------------------------------------------------------------------
module mono_lcd_page_refresh #(
    parameter int PANEL_WIDTH  = 128,
    parameter int PANEL_HEIGHT = 64
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [9:0] fb_address, [17:10] fb_byte, rest zero
    input  logic [0:0]  s_tuser,   // [0] func

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] bus_byte
    output logic [0:0]  m_tuser,   // [0] is_data
    output logic        m_tlast,   // frame_done

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data   // column_offset
);

    // Geometry
    localparam int ROW_BYTES   = PANEL_WIDTH / 8;
    localparam int PAGE_COUNT  = PANEL_HEIGHT / 8;
    localparam int STORE_BYTES = ROW_BYTES * PANEL_HEIGHT;
    localparam int PAGE_BYTES  = ROW_BYTES * 8;
    localparam int LAST_STEP   = PANEL_WIDTH + 2;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int STEP_W      = $clog2(PANEL_WIDTH + 3);
    localparam int PAGE_W      = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int CMP_W       = ((ADDR_W > 10) ? ADDR_W : 10) + 1;

    mlpr_pkg::mlpr_state_t state_reg, state_next;

    logic [ADDR_W-1:0] clr_addr_reg;
    logic [6:0]        col_off_reg;
    logic [PAGE_W-1:0] page_reg;
    logic [STEP_W-1:0] step_reg;
    logic [ADDR_W-1:0] page_base_reg;
    logic [ADDR_W-1:0] row_addr_reg;
    logic [2:0]        bit_sel_reg;
    logic [3:0]        cnt_reg;
    logic [7:0]        res_byte_reg;
    logic              res_is_data_reg;
    logic              res_done_reg;
    logic              m_tvalid_reg;
    logic [7:0]        m_byte_reg;
    logic              m_is_data_reg;
    logic              m_done_reg;

    // Input fields
    logic [9:0]        fb_address;
    logic [7:0]        fb_byte;
    logic              func;
    logic              in_accept;
    logic              is_refresh;
    logic              is_cmd_step;
    logic [CMP_W-1:0]  wr_addr_full;
    logic              wr_in_range;
    logic [STEP_W-1:0] col;
    logic              last_step;
    logic              last_page;

    // RAM ports
    logic              ram_wr_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    logic [7:0]        ram_wr_data;
    logic [7:0]        ram_rd_data;
    logic              emit_load;
    logic              clear_last;
    logic [7:0]        cmd_byte;

    assign fb_address = s_tdata[9:0];
    assign fb_byte    = s_tdata[17:10];
    assign func       = s_tuser[0];
    assign in_accept  = s_tvalid & s_tready;
    assign is_refresh = (func == mlpr_pkg::FUNC_REFRESH);
    assign is_cmd_step = (step_reg < STEP_W'(mlpr_pkg::CMD_STEPS));

    assign wr_addr_full = CMP_W'(fb_address);
    assign wr_in_range  = (wr_addr_full < CMP_W'(STORE_BYTES));
    assign col          = step_reg - STEP_W'(mlpr_pkg::CMD_STEPS);
    assign last_step    = (step_reg == STEP_W'(LAST_STEP));
    assign last_page    = (page_reg == PAGE_W'(PAGE_COUNT - 1));
    assign clear_last   = (clr_addr_reg == ADDR_W'(STORE_BYTES - 1));

    // Command byte for the current step
    always_comb
    begin
        case (step_reg[1:0])
            2'd0:    cmd_byte = mlpr_pkg::CMD_PAGE_BASE + 8'(page_reg);
            2'd1:    cmd_byte = mlpr_pkg::CMD_COL_LOW | {4'h0, col_off_reg[3:0]};
            2'd2:    cmd_byte = mlpr_pkg::CMD_COL_HIGH | {5'h00, col_off_reg[6:4]};
            default: cmd_byte = 8'h00;
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mlpr_pkg::ST_CLEAR:
            begin
                if (clear_last)
                begin
                    state_next = mlpr_pkg::ST_IDLE;
                end
            end
            mlpr_pkg::ST_IDLE:
            begin
                if (s_tvalid && is_refresh)
                begin
                    state_next = is_cmd_step ? mlpr_pkg::ST_EMIT : mlpr_pkg::ST_GATHER;
                end
            end
            mlpr_pkg::ST_GATHER:
            begin
                if (cnt_reg == mlpr_pkg::GATHER_LAST)
                begin
                    state_next = mlpr_pkg::ST_EMIT;
                end
            end
            mlpr_pkg::ST_EMIT:
            begin
                if (emit_load)
                begin
                    state_next = mlpr_pkg::ST_IDLE;
                end
            end
            default: state_next = mlpr_pkg::ST_CLEAR;
        endcase
    end

    // State outputs
    always_comb
    begin
        s_tready    = 1'b0;
        ram_wr_en   = 1'b0;
        ram_wr_addr = wr_addr_full[ADDR_W-1:0];
        ram_wr_data = fb_byte;
        emit_load   = 1'b0;
        case (state_reg)
            mlpr_pkg::ST_CLEAR:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = clr_addr_reg;
                ram_wr_data = 8'h00;
            end
            mlpr_pkg::ST_IDLE:
            begin
                s_tready  = 1'b1;
                ram_wr_en = s_tvalid & ~is_refresh & wr_in_range;
            end
            mlpr_pkg::ST_EMIT:
            begin
                emit_load = ~m_tvalid_reg | m_tready;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    mlpr_ram #(
        .WIDTH (8),
        .DEPTH (STORE_BYTES)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (row_addr_reg),
        .rd_data (ram_rd_data)
    );

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mlpr_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Clearing pass address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (state_reg == mlpr_pkg::ST_CLEAR)
        begin
            clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
        end
    end

    // Column offset register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_off_reg <= '0;
        end
        else if (cfg_valid)
        begin
            col_off_reg <= cfg_data;
        end
    end

    // Refresh position, advanced when a request is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_reg      <= '0;
            step_reg      <= '0;
            page_base_reg <= '0;
        end
        else if (in_accept && is_refresh)
        begin
            if (last_step)
            begin
                step_reg <= '0;
                if (last_page)
                begin
                    page_reg      <= '0;
                    page_base_reg <= '0;
                end
                else
                begin
                    page_reg      <= page_reg + PAGE_W'(1);
                    page_base_reg <= page_base_reg + ADDR_W'(PAGE_BYTES);
                end
            end
            else
            begin
                step_reg <= step_reg + STEP_W'(1);
            end
        end
    end

    // Result build: command in one step, data one row bit per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (state_reg == mlpr_pkg::ST_GATHER)
        begin
            cnt_reg <= cnt_reg + 4'd1;
        end
        else
        begin
            cnt_reg <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && is_refresh)
        begin
            res_is_data_reg <= ~is_cmd_step;
            res_done_reg    <= last_step & last_page;
            res_byte_reg    <= cmd_byte;
            row_addr_reg    <= page_base_reg + ADDR_W'(col >> 3);
            bit_sel_reg     <= 3'd7 - col[2:0];
        end
        else if (state_reg == mlpr_pkg::ST_GATHER)
        begin
            row_addr_reg <= row_addr_reg + ADDR_W'(ROW_BYTES);
            if (cnt_reg != 4'd0)
            begin
                // top row ends up in bit 0 after eight shifts
                res_byte_reg <= {ram_rd_data[bit_sel_reg], res_byte_reg[7:1]};
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (emit_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_load)
        begin
            m_byte_reg    <= res_byte_reg;
            m_is_data_reg <= res_is_data_reg;
            m_done_reg    <= res_done_reg;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_byte_reg;
    assign m_tuser[0] = m_is_data_reg;
    assign m_tlast    = m_done_reg;

endmodule

/* test/tb_mono_lcd_page_refresh.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_mono_lcd_page_refresh
// Self-checking bench for the page-mode LCD framebuffer and refresh sequencer.
// Host words (framebuffer writes and refresh requests) go in on the slave
// stream. A local model of the framebuffer and the page/step counters
// predicts every bus byte, which is compared field by field with the master
// stream. Directed words hit the command header, the column gather and
// writes racing the refresh. Random traffic then runs over several column
// offsets, with random gaps and stalls on both streams but for the last, quiet run.
// ---------------------------------------------------------------------------
module tb_mono_lcd_page_refresh;

    localparam int PANEL_WIDTH  = 128;
    localparam int PANEL_HEIGHT = 64;
    localparam int ROW_BYTES    = PANEL_WIDTH / 8;
    localparam int PAGE_COUNT   = PANEL_HEIGHT / 8;
    localparam int STORE_BYTES  = ROW_BYTES * PANEL_HEIGHT;
    localparam int PAGE_STEPS   = PANEL_WIDTH + mlpr_pkg::CMD_STEPS;
    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 9;
    localparam int SETTLE_WAIT  = 20;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int REPORT_MAX   = 10;

    // Three command steps at the head of a page
    localparam int STEP_PAGE_CMD = 0;
    localparam int STEP_COL_LOW  = 1;
    localparam int STEP_COL_HIGH = 2;

    typedef struct packed {
        logic       is_data;
        logic [7:0] bus_byte;
        logic       frame_done;
    } lcd_word_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [6:0]  cfg_data;

    // Model state
    logic [7:0]  fb_model [0:STORE_BYTES-1];
    int          page_now;
    int          step_now;
    logic [6:0]  col_offset_now;
    lcd_word_t   expected_bus_q [$];

    int          fail_count;
    int          cycle_count;
    int          stall_left;
    logic        calm;

    mono_lcd_page_refresh #(
        .PANEL_WIDTH  (PANEL_WIDTH),
        .PANEL_HEIGHT (PANEL_HEIGHT)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #CLK_HALF clk = ~clk;

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Collect the 8 vertical pixels of one column in a page, top row in bit 0
    function automatic logic [7:0] gather_column(int page, int col);
        logic [7:0] acc;
        int         idx;
        acc = 8'h00;
        for (int k = 0; k < mlpr_pkg::PAGE_ROWS; k++)
        begin
            idx = (page * mlpr_pkg::PAGE_ROWS + k) * ROW_BYTES + (col / 8);
            if (idx < STORE_BYTES)
                acc[k] = fb_model[idx][7 - (col % 8)];
        end
        return acc;
    endfunction

    // Apply one accepted host word to the model, queue the bus byte it causes
    task automatic record_host_word(logic func, logic [9:0] addr, logic [7:0] data);
        lcd_word_t w;
        if (func == mlpr_pkg::FUNC_WRITE)
        begin
            if (addr < STORE_BYTES)
                fb_model[addr] = data;
        end
        else
        begin
            w = '0;
            case (step_now)
                STEP_PAGE_CMD:
                    w.bus_byte = mlpr_pkg::CMD_PAGE_BASE + 8'(page_now);
                STEP_COL_LOW:
                    w.bus_byte = mlpr_pkg::CMD_COL_LOW + {4'h0, col_offset_now[3:0]};
                STEP_COL_HIGH:
                    w.bus_byte = mlpr_pkg::CMD_COL_HIGH + {5'h00, col_offset_now[6:4]};
                default:
                begin
                    w.is_data  = 1'b1;
                    w.bus_byte = gather_column(page_now, step_now - mlpr_pkg::CMD_STEPS);
                end
            endcase
            step_now++;
            if (step_now >= PAGE_STEPS)
            begin
                step_now = 0;
                page_now++;
                if (page_now >= PAGE_COUNT)
                begin
                    page_now     = 0;
                    w.frame_done = 1'b1;
                end
            end
            expected_bus_q.push_back(w);
        end
    endtask

    // Send one host word, with an optional idle burst in front of it
    task automatic push_host_word(logic func, logic [9:0] addr, logic [7:0] data);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {6'h00, data, addr};
        do @(posedge clk); while (!s_tready);
        record_host_word(func, addr, data);
    endtask

    task automatic drain_bus_bytes();
        s_tvalid <= 1'b0;
        while (expected_bus_q.size() != 0)
            @(posedge clk);
    endtask

    // Column offset is only changed with the block idle
    task automatic set_column_offset(logic [6:0] value);
        drain_bus_bytes();
        repeat (SETTLE_WAIT) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid      <= 1'b0;
        col_offset_now  = value;
    endtask

    // Receiver stalls in random bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (!calm && $urandom_range(0, 7) == 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 15);
        end
        else
            m_tready <= 1'b1;
    end

    // Compare each bus byte with the oldest prediction
    always @(posedge clk)
    begin
        lcd_word_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_bus_q.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_MAX)
                    $display("unexpected bus word: is_data=%0d byte=%02h last=%0d",
                             m_tuser[0], m_tdata, m_tlast);
            end
            else
            begin
                want = expected_bus_q.pop_front();
                if (want.is_data !== m_tuser[0] || want.bus_byte !== m_tdata ||
                    want.frame_done !== m_tlast)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display({"bus word mismatch: exp is_data=%0d byte=%02h last=%0d,",
                                  " got is_data=%0d byte=%02h last=%0d"},
                                 want.is_data, want.bus_byte, want.frame_done,
                                 m_tuser[0], m_tdata, m_tlast);
                end
            end
        end
    end

    // Page header with the largest column offset
    task automatic test_command_header();
        set_column_offset(7'd127);
        repeat (mlpr_pkg::CMD_STEPS) push_host_word(mlpr_pkg::FUNC_REFRESH, 10'h3FF, 8'hFF);
    endtask

    // Corner pixels and the column gather order
    task automatic test_pixel_gather();
        push_host_word(mlpr_pkg::FUNC_WRITE, 10'd0, 8'hFF);
        push_host_word(mlpr_pkg::FUNC_WRITE, 10'd16, 8'h80);
        push_host_word(mlpr_pkg::FUNC_WRITE, 10'd15, 8'h01);
        push_host_word(mlpr_pkg::FUNC_WRITE, 10'd1023, 8'hFF);
        push_host_word(mlpr_pkg::FUNC_WRITE, 10'd341, 8'h5A);
        repeat (2) push_host_word(mlpr_pkg::FUNC_REFRESH, 10'd0, 8'h00);
    endtask

    // A write lands between data bytes of the same page
    task automatic test_write_during_refresh();
        push_host_word(mlpr_pkg::FUNC_WRITE, 10'd0, 8'h00);
        repeat (2) push_host_word(mlpr_pkg::FUNC_REFRESH, 10'd512, 8'hA5);
        push_host_word(mlpr_pkg::FUNC_WRITE, 10'd0, 8'hFF);
        push_host_word(mlpr_pkg::FUNC_REFRESH, 10'd0, 8'h00);
    endtask

    // Mostly refresh requests with framebuffer writes mixed in
    task automatic test_random_traffic(int count, logic [6:0] offset, logic quiet);
        logic func;
        set_column_offset(offset);
        calm <= quiet;
        for (int n = 0; n < count; n++)
        begin
            func = ($urandom_range(0, 99) < 78) ? mlpr_pkg::FUNC_REFRESH : mlpr_pkg::FUNC_WRITE;
            push_host_word(func, 10'($urandom_range(0, 1023)), 8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        rst_n       <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= mlpr_pkg::FUNC_WRITE;
        m_tready    <= 1'b0;
        cfg_valid   <= 1'b0;
        cfg_data    <= '0;
        calm        <= 1'b0;
        stall_left   = 0;
        fail_count   = 0;
        cycle_count  = 0;
        page_now     = 0;
        step_now     = 0;
        col_offset_now = '0;
        for (int i = 0; i < STORE_BYTES; i++)
            fb_model[i] = 8'h00;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_command_header();
        test_pixel_gather();
        test_write_during_refresh();
        test_random_traffic(370, 7'd0, 1'b0);
        test_random_traffic(370, 7'd15, 1'b0);
        test_random_traffic(370, 7'd16, 1'b0);
        test_random_traffic(370, 7'($urandom_range(0, 127)), 1'b0);
        test_random_traffic(370, 7'd127, 1'b1);

        drain_bus_bytes();
        repeat (SETTLE_WAIT) @(posedge clk);
        if (fail_count == 0 && expected_bus_q.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
